// File: design/nhdec_pkg.sv
// shared types and constants of the cartridge header decoder
// no dependencies; compiled before the files that import it
package nhdec_pkg;

    // header layout
    localparam int unsigned HDR_LEN      = 16;
    localparam int unsigned FIRST_STORED = 4;
    localparam int unsigned N_STORED     = HDR_LEN - FIRST_STORED;
    localparam int unsigned POS_W        = 5;
    localparam int unsigned IDX_W        = 4;

    // magic 'N','E','S',0x1A, entry k is header byte k
    localparam logic [3:0][7:0] MAGIC = {8'h1A, 8'h53, 8'h45, 8'h4E};

    // format and console codes
    localparam logic [3:0] FMT_MASK     = 4'hC;
    localparam logic [3:0] FMT_NES20    = 4'h8;
    localparam logic [1:0] CONSOLE_VS   = 2'd1;
    localparam logic [1:0] CONSOLE_EXT  = 2'd3;
    localparam logic [3:0] EXT_DECIMAL  = 4'd3;
    localparam logic [7:0] JUNK_LIMIT   = 8'h20;

    // result codes
    localparam logic [1:0] MIR_HORIZONTAL = 2'd0;
    localparam logic [1:0] MIR_FOUR       = 2'd2;
    localparam logic [1:0] TIMING_NTSC    = 2'd0;
    localparam logic [1:0] TIMING_PAL     = 2'd1;
    localparam logic [1:0] TIMING_DENDY   = 2'd2;
    localparam logic [15:0] INES_RAM_CODES = 16'h0707;

    // stored header bytes, entry k is header byte FIRST_STORED + k
    typedef logic [N_STORED-1:0][7:0] t_hdr_bytes;

    // capture stage to decode stage
    typedef struct packed {
        logic       valid;
        logic       magic_ok;
        t_hdr_bytes bytes;
    } t_cap_out;

endpackage

// File: design/nhdec_if.sv
// handshake channels of the header decoder: byte input and decoded record output
// no dependencies
interface nhdec_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;
    logic       restart;

    modport source (output valid, output header_byte, output restart, input ready);
    modport sink   (input valid, input header_byte, input restart, output ready);
endinterface

interface nhdec_rec_if;
    logic        valid;
    logic        ready;
    logic        header_ok;
    logic        is_nes20;
    logic [11:0] mapper_number;
    logic [3:0]  submapper_number;
    logic [31:0] prg_bytes;
    logic [31:0] chr_bytes;
    logic [1:0]  mirroring;
    logic [2:0]  board_flags;
    logic [1:0]  timing_mode;
    logic [15:0] ram_shift_codes;
    logic [13:0] console_info;
    logic [7:0]  expansion_device;

    modport source (
        output valid, output header_ok, output is_nes20, output mapper_number,
        output submapper_number, output prg_bytes, output chr_bytes, output mirroring,
        output board_flags, output timing_mode, output ram_shift_codes,
        output console_info, output expansion_device, input ready
    );
    modport sink (
        input valid, input header_ok, input is_nes20, input mapper_number,
        input submapper_number, input prg_bytes, input chr_bytes, input mirroring,
        input board_flags, input timing_mode, input ram_shift_codes,
        input console_info, input expansion_device, output ready
    );
endinterface

// File: design/nhdec_capture.sv
// byte capture stage: position counter, magic check and storage of bytes 4..15
// depends on nhdec_pkg and nhdec_byte_if
module nhdec_capture (
    input  logic              i_clk,
    input  logic              i_rst_n,
    nhdec_byte_if.sink        i_hdr,
    input  logic              i_dn_ready,
    output nhdec_pkg::t_cap_out o_cap
);
    import nhdec_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_magic, n_magic;
    logic             r_pend, n_pend;
    t_hdr_bytes       r_store;

    logic             w_accept;
    logic [POS_W-1:0] w_pos;
    logic             w_magic;
    logic             w_store_en;
    logic [IDX_W-1:0] w_idx;

    // input is ready unless a finished header waits and the decode stage cannot take it
    assign i_hdr.ready = !r_pend || i_dn_ready;
    assign w_accept    = i_hdr.valid && i_hdr.ready;

    // restart rewinds position and magic before the beat is handled
    assign w_pos   = i_hdr.restart ? '0 : r_pos;
    assign w_magic = i_hdr.restart ? 1'b1 : r_magic;

    assign w_store_en = w_accept && (w_pos >= POS_W'(FIRST_STORED))
                        && (w_pos < POS_W'(HDR_LEN));
    assign w_idx      = IDX_W'(w_pos - POS_W'(FIRST_STORED));

    // next position, magic flag and pending record
    always_comb begin
        n_pos   = r_pos;
        n_magic = r_magic;
        n_pend  = r_pend && !i_dn_ready;
        if (w_accept) begin
            n_pos   = w_pos;
            n_magic = w_magic;
            if (w_pos < POS_W'(HDR_LEN)) begin
                n_pos = w_pos + POS_W'(1);
                if (w_pos < POS_W'(FIRST_STORED)) begin
                    if (i_hdr.header_byte != MAGIC[w_pos[1:0]]) begin
                        n_magic = 1'b0;
                    end
                end
                if (w_pos == POS_W'(HDR_LEN - 1)) begin
                    n_pend = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_magic <= 1'b1;
            r_pend  <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_magic <= n_magic;
            r_pend  <= n_pend;
        end
    end

    // byte store, no reset: every entry is written before a record reads it
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N_STORED; k++) begin
            if (w_store_en && (w_idx == IDX_W'(k))) begin
                r_store[k] <= i_hdr.header_byte;
            end
        end
    end

    assign o_cap.valid    = r_pend;
    assign o_cap.magic_ok = r_magic;
    assign o_cap.bytes    = r_store;

    // a pending record always follows the last header byte
    a_pend_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_pos == POS_W'(HDR_LEN)))
        else $error("pending record without a complete header");

    // a stalled record freezes the capture state
    a_pend_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !i_dn_ready) |=> (r_pend && $stable(r_pos) && $stable(r_store)))
        else $error("capture state moved under a stalled record");

endmodule

// File: design/nhdec_decode.sv
// decode stage: turns the captured header into one record and holds it in the result register
// depends on nhdec_pkg and nhdec_rec_if
module nhdec_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nhdec_pkg::t_cap_out i_cap,
    output logic                o_up_ready,
    nhdec_rec_if.source         o_rec
);
    import nhdec_pkg::*;

    // rom size: linear count of units or exponent-multiplier form, saturated
    function automatic logic [31:0] f_rom_size(input logic [11:0] r, input logic chr_unit);
        logic [5:0]  e;
        logic [33:0] t;
        logic [31:0] lin;
        e   = r[7:2];
        t   = 34'({r[1:0], 1'b1}) << e[4:0];
        lin = chr_unit ? {7'b0, r, 13'b0} : {6'b0, r, 14'b0};
        if (r[11:8] != 4'hF) begin
            return lin;
        end else if (e[5] || (t[33:32] != 2'b00)) begin
            return '1;
        end else begin
            return t[31:0];
        end
    endfunction

    logic        r_valid;
    logic        r_ok, n_ok;
    logic        r_nes20, n_nes20;
    logic [11:0] r_mapper, n_mapper;
    logic [3:0]  r_sub, n_sub;
    logic [31:0] r_prg, n_prg;
    logic [31:0] r_chr, n_chr;
    logic [1:0]  r_mir, n_mir;
    logic [2:0]  r_board, n_board;
    logic [1:0]  r_timing, n_timing;
    logic [15:0] r_ram, n_ram;
    logic [13:0] r_console, n_console;
    logic [7:0]  r_exp, n_exp;

    logic        w_load;

    assign o_up_ready = !r_valid || o_rec.ready;
    assign w_load     = i_cap.valid && o_up_ready;

    // field decode
    always_comb begin
        logic [7:0] b4, b5, b6, b7, b8, b9, b10, b11, b12, b13, b14, b15;
        logic [3:0] ext, ppu, mode;
        logic       junk;
        b4  = i_cap.bytes[0];
        b5  = i_cap.bytes[1];
        b6  = i_cap.bytes[2];
        b7  = i_cap.bytes[3];
        b8  = i_cap.bytes[4];
        b9  = i_cap.bytes[5];
        b10 = i_cap.bytes[6];
        b11 = i_cap.bytes[7];
        b12 = i_cap.bytes[8];
        b13 = i_cap.bytes[9];
        b14 = i_cap.bytes[10];
        b15 = i_cap.bytes[11];
        ext  = '0;
        ppu  = '0;
        mode = '0;
        junk = (b12 >= JUNK_LIMIT) || (b13 >= JUNK_LIMIT)
               || (b14 >= JUNK_LIMIT) || (b15 >= JUNK_LIMIT);

        n_ok      = 1'b0;
        n_nes20   = 1'b0;
        n_mapper  = '0;
        n_sub     = '0;
        n_prg     = '0;
        n_chr     = '0;
        n_mir     = MIR_HORIZONTAL;
        n_board   = '0;
        n_timing  = TIMING_NTSC;
        n_ram     = '0;
        n_console = '0;
        n_exp     = '0;

        if (i_cap.magic_ok) begin
            n_ok    = 1'b1;
            n_mir   = b6[3] ? MIR_FOUR : {1'b0, b6[0]};
            n_board = {1'b0, b6[2], b6[1]};
            if ((b7[3:0] & FMT_MASK) == FMT_NES20) begin
                n_nes20  = 1'b1;
                n_mapper = {b8[3:0], b7[7:4], b6[7:4]};
                n_sub    = b8[7:4];
                n_prg    = f_rom_size({b9[3:0], b4}, 1'b0);
                n_chr    = f_rom_size({b9[7:4], b5}, 1'b1);
                // console type: vs system or extended console
                if (b7[1:0] == CONSOLE_VS) begin
                    ext  = 4'd1;
                    ppu  = b13[3:0];
                    mode = b13[7:4];
                end else if (b7[1:0] == CONSOLE_EXT) begin
                    ext = b13[3:0];
                    if (ext inside {[4'd0:4'd2]}) begin
                        mode = ext;
                    end else if (ext == EXT_DECIMAL) begin
                        n_board[2] = 1'b1;
                    end
                end
                case (b12[1:0])
                    2'd1:    n_timing = TIMING_PAL;
                    2'd3:    n_timing = TIMING_DENDY;
                    default: n_timing = TIMING_NTSC;
                endcase
                n_ram     = {b11, b10};
                n_console = {b14[1:0], mode, ppu, ext};
                n_exp     = b15;
            end else begin
                n_prg = {10'b0, b4, 14'b0};
                n_chr = {11'b0, b5, 13'b0};
                if (junk) begin
                    n_mapper = {8'b0, b6[7:4]};
                    n_timing = TIMING_NTSC;
                end else begin
                    n_mapper = {4'b0, b7[7:4], b6[7:4]};
                    n_timing = {1'b0, b9[0]};
                end
                n_ram = INES_RAM_CODES;
            end
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (o_rec.ready) begin
            r_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ok      <= n_ok;
            r_nes20   <= n_nes20;
            r_mapper  <= n_mapper;
            r_sub     <= n_sub;
            r_prg     <= n_prg;
            r_chr     <= n_chr;
            r_mir     <= n_mir;
            r_board   <= n_board;
            r_timing  <= n_timing;
            r_ram     <= n_ram;
            r_console <= n_console;
            r_exp     <= n_exp;
        end
    end

    assign o_rec.valid            = r_valid;
    assign o_rec.header_ok        = r_ok;
    assign o_rec.is_nes20         = r_nes20;
    assign o_rec.mapper_number    = r_mapper;
    assign o_rec.submapper_number = r_sub;
    assign o_rec.prg_bytes        = r_prg;
    assign o_rec.chr_bytes        = r_chr;
    assign o_rec.mirroring        = r_mir;
    assign o_rec.board_flags      = r_board;
    assign o_rec.timing_mode      = r_timing;
    assign o_rec.ram_shift_codes  = r_ram;
    assign o_rec.console_info     = r_console;
    assign o_rec.expansion_device = r_exp;

    // a bad magic record carries nothing but zeros
    a_bad_magic_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_ok) |-> (!r_nes20 && (r_mapper == '0) && (r_prg == '0)
                                && (r_chr == '0) && (r_ram == '0) && (r_board == '0)))
        else $error("bad magic record with nonzero fields");

    // an ines 1.0 record has no nes 2.0 only fields
    a_ines_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_nes20) |-> ((r_sub == '0) && (r_console == '0) && (r_exp == '0)
                                   && (r_mapper[11:8] == '0)))
        else $error("ines 1.0 record with nes 2.0 fields set");

endmodule

// File: design/ines_nes20_header_decoder.sv
// top level of the iNES 1.0 / NES 2.0 cartridge header decoder
// depends on nhdec_pkg, nhdec_if, nhdec_capture and nhdec_decode

// The decoder takes one header byte per beat on i_hdr and can accept a byte in
// every cycle. A beat with restart set marks byte 0 of a new header; bytes after
// byte 15 without a restart are taken and ignored. Once byte 15 is taken, the
// finished header is held in the capture stage until the result register is free,
// then decoded into one record that is loaded into it and offered on o_rec;
// the next header keeps streaming while the record waits. Input ready drops only
// when a finished header is waiting on the capture stage and the result register
// is still held by the sink. Bad magic gives a record with header_ok low and all
// other fields zero.
module ines_nes20_header_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nhdec_byte_if.sink  i_hdr,
    nhdec_rec_if.source o_rec
);
    import nhdec_pkg::*;

    t_cap_out w_cap;
    logic     w_dn_ready;

    // position, magic and byte store
    nhdec_capture u_capture (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hdr      (i_hdr),
        .i_dn_ready (w_dn_ready),
        .o_cap      (w_cap)
    );

    // field decode and result register
    nhdec_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cap      (w_cap),
        .o_up_ready (w_dn_ready),
        .o_rec      (o_rec)
    );

endmodule
